// ===== hw/rtl/rhss_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Rolling hash substring search: shared definitions
// Widths, register indexes, sequencer states and the control bundles that
// pass between the sequencer, the modular reducers and the byte window.
// ----------------------------------------------------------------------------
package rhss_pkg;

    localparam int BYTE_W     = 8;
    localparam int CFG_W      = 64;
    localparam int HALF_BYTES = CFG_W / BYTE_W;
    localparam int MAX_PAT    = 2 * HALF_BYTES;
    localparam int PAT_W      = MAX_PAT * BYTE_W;
    localparam int IDX_W      = $clog2(MAX_PAT);
    localparam int LEN_W      = 5;
    localparam int HASH_W     = 16;
    localparam int POS_W      = 32;
    localparam int START_W    = 32;
    localparam int TOTAL_W    = 16;
    localparam int STREAM_W   = BYTE_W + HASH_W + BYTE_W;
    localparam int CNT_W      = $clog2(PAT_W);
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_LENGTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_LO  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_HI  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS = 2'd3;

    localparam logic [HASH_W-1:0] MODULUS_RESET = 16'd11;
    localparam logic [HASH_W-1:0] MODULUS_MIN   = 16'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAT,
        ST_PSAVE,
        ST_PREP,
        ST_HASH,
        ST_HDONE,
        ST_CHECK,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic clear;
        logic step;
        logic din;
    } red_ctl_t;

    typedef struct packed {
        logic              clear;
        logic              shift;
        logic [BYTE_W-1:0] din;
        logic [IDX_W-1:0]  addr;
    } win_ctl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/rhss_modred.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Bit-serial modular reducer
// Folds one bit per cycle into a residue while step is set: acc = (2 * acc + bit) mod q, using
// a single compare and subtract.
// ----------------------------------------------------------------------------
module rhss_modred
    import rhss_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  red_ctl_t          ctl,
    input  logic [HASH_W-1:0] modulus,
    output logic [HASH_W-1:0] acc
);

    logic [HASH_W-1:0] acc_reg;
    logic [HASH_W-1:0] acc_next;
    logic [HASH_W:0]   doubled;

    assign doubled = {acc_reg, ctl.din};

    always_comb
    begin
        acc_next = acc_reg;
        if (ctl.clear)
        begin
            acc_next = '0;
        end
        else if (ctl.step)
        begin
            if (doubled >= {1'b0, modulus})
            begin
                acc_next = HASH_W'(doubled - {1'b0, modulus});
            end
            else
            begin
                acc_next = doubled[HASH_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/rhss_window.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Text window
// Shift line holding the most recent text bytes, newest at entry zero, with
// one read port at a selected entry.
// ----------------------------------------------------------------------------
module rhss_window
    import rhss_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  win_ctl_t          ctl,
    output logic [BYTE_W-1:0] rd_byte
);

    logic [BYTE_W-1:0] win_reg  [MAX_PAT];
    logic [BYTE_W-1:0] win_next [MAX_PAT];

    always_comb
    begin
        for (int i = 0; i < MAX_PAT; i++)
        begin
            win_next[i] = win_reg[i];
        end
        if (ctl.clear)
        begin
            for (int i = 0; i < MAX_PAT; i++)
            begin
                win_next[i] = '0;
            end
        end
        else if (ctl.shift)
        begin
            win_next[0] = ctl.din;
            for (int i = 1; i < MAX_PAT; i++)
            begin
                win_next[i] = win_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_PAT; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < MAX_PAT; i++)
            begin
                win_reg[i] <= win_next[i];
            end
        end
    end

    assign rd_byte = win_reg[ctl.addr];

endmodule
`default_nettype wire

// ===== hw/rtl/rolling_hash_substring_search.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Rolling hash substring search
// Streams text bytes, keeps a base-256 rolling hash of the last m bytes modulo
// a configured modulus, and checks every hash hit byte by byte.
// ----------------------------------------------------------------------------
// One text byte is taken per input transfer and one result is produced for
// it. The block takes no new byte until it is through with the current one:
// it hashes the byte, then compares window and pattern byte by byte (up to 16
// comparisons) when the window hash equals the pattern hash. A byte that
// starts a new text first hashes the pattern and the leading weight. Hashing
// is done by the two bit-serial modular reducers, which fold a 32-bit stream
// one bit per cycle. A result waiting in the output register does not block
// acceptance of the next byte.
// ----------------------------------------------------------------------------
module rolling_hash_substring_search
    import rhss_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [BYTE_W-1:0]    text_byte,
    input  logic                 first_byte,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 window_full,
    output logic                 match_found,
    output logic                 spurious_hit,
    output logic [LEN_W-1:0]     compare_count,
    output logic [START_W-1:0]   match_start,
    output logic [TOTAL_W-1:0]   spurious_total
);

    logic [LEN_W-1:0]   len_reg;
    logic [CFG_W-1:0]   pat_lo_reg;
    logic [CFG_W-1:0]   pat_hi_reg;
    logic [HASH_W-1:0]  mod_reg;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [LEN_W-1:0]   cmp_reg, cmp_next;
    logic               was_full_reg, was_full_next;
    logic               found_reg, found_next;
    logic               spur_hit_reg, spur_hit_next;
    logic [HASH_W-1:0]  wh_reg, wh_next;
    logic [HASH_W-1:0]  ph_reg, ph_next;
    logic [HASH_W-1:0]  lw_reg, lw_next;
    logic [LEN_W-1:0]   bs_reg, bs_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [TOTAL_W-1:0] spur_reg, spur_next;
    logic               ov_reg, ov_next;

    logic [BYTE_W-1:0]   byte_reg, byte_next;
    logic [STREAM_W-1:0] sa_reg, sa_next;
    logic [STREAM_W-1:0] sb_reg, sb_next;
    logic [PAT_W-1:0]    pat_sr_reg, pat_sr_next;
    logic                o_full_reg, o_full_next;
    logic                o_found_reg, o_found_next;
    logic                o_spur_reg, o_spur_next;
    logic [LEN_W-1:0]    o_cmp_reg, o_cmp_next;
    logic [START_W-1:0]  o_start_reg, o_start_next;
    logic [TOTAL_W-1:0]  o_total_reg, o_total_next;

    logic [LEN_W-1:0]          m_eff;
    logic [HASH_W-1:0]         q_eff;
    logic [PAT_W-1:0]          pat_flat;
    logic [LEN_W-1:0]          rd_index;
    logic [LEN_W+2:0]          pat_bits;
    logic [CNT_W-1:0]          pat_last;
    logic [BYTE_W+HASH_W-1:0]  drop_prod;
    logic [HASH_W-1:0]         acc_a;
    logic [HASH_W-1:0]         acc_b;
    logic [HASH_W-1:0]         wh_new;
    logic [LEN_W-1:0]          bs_inc;
    logic                      full_after;
    logic                      full_now;
    logic [POS_W+START_W-1:0]  pos_ext;
    logic [START_W-1:0]        start_sat;
    logic [BYTE_W-1:0]         win_rd;
    red_ctl_t                  red_a;
    red_ctl_t                  red_b;
    win_ctl_t                  win;

    always_comb
    begin
        m_eff = len_reg;
        if (len_reg == '0)
        begin
            m_eff = LEN_W'(1);
        end
        else if (len_reg > LEN_W'(MAX_PAT))
        begin
            m_eff = LEN_W'(MAX_PAT);
        end
    end

    assign q_eff = (mod_reg < MODULUS_MIN) ? MODULUS_MIN : mod_reg;

    always_comb
    begin
        for (int i = 0; i < HALF_BYTES; i++)
        begin
            pat_flat[PAT_W-1-BYTE_W*i -: BYTE_W] = pat_lo_reg[BYTE_W*i +: BYTE_W];
            pat_flat[PAT_W-1-BYTE_W*(i+HALF_BYTES) -: BYTE_W] =
                pat_hi_reg[BYTE_W*i +: BYTE_W];
        end
    end

    assign rd_index  = m_eff - LEN_W'(1) - {1'b0, idx_reg};
    assign pat_bits  = {m_eff, 3'b000};
    assign pat_last  = CNT_W'(pat_bits - 1'b1);
    assign drop_prod = {{HASH_W{1'b0}}, win_rd} * {{BYTE_W{1'b0}}, lw_reg};
    assign wh_new    = (acc_a >= acc_b) ? (acc_a - acc_b) : (acc_a + (q_eff - acc_b));
    assign bs_inc    = bs_reg + LEN_W'(1);
    assign full_after = was_full_reg || (bs_inc >= m_eff);
    assign full_now  = bs_reg >= m_eff;
    assign pos_ext   = {{START_W{1'b0}}, pos_reg};
    assign start_sat = (|pos_ext[POS_W+START_W-1:START_W]) ? '1 : pos_ext[START_W-1:0];

    rhss_modred u_red_a (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (red_a),
        .modulus (q_eff),
        .acc     (acc_a)
    );

    rhss_modred u_red_b (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (red_b),
        .modulus (q_eff),
        .acc     (acc_b)
    );

    rhss_window u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (win),
        .rd_byte (win_rd)
    );

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        idx_next      = idx_reg;
        cmp_next      = cmp_reg;
        was_full_next = was_full_reg;
        found_next    = found_reg;
        spur_hit_next = spur_hit_reg;
        wh_next       = wh_reg;
        ph_next       = ph_reg;
        lw_next       = lw_reg;
        bs_next       = bs_reg;
        pos_next      = pos_reg;
        spur_next     = spur_reg;
        ov_next       = ov_reg;
        byte_next     = byte_reg;
        sa_next       = sa_reg;
        sb_next       = sb_reg;
        pat_sr_next   = pat_sr_reg;
        o_full_next   = o_full_reg;
        o_found_next  = o_found_reg;
        o_spur_next   = o_spur_reg;
        o_cmp_next    = o_cmp_reg;
        o_start_next  = o_start_reg;
        o_total_next  = o_total_reg;
        red_a         = '{clear: 1'b0, step: 1'b0, din: 1'b0};
        red_b         = '{clear: 1'b0, step: 1'b0, din: 1'b0};
        win.clear     = 1'b0;
        win.shift     = 1'b0;
        win.din       = byte_reg;
        win.addr      = rd_index[IDX_W-1:0];

        if (ov_reg && !out_stall)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                red_a.clear = 1'b1;
                red_b.clear = 1'b1;
                cnt_next    = '0;
                idx_next    = '0;
                if (in_valid)
                begin
                    byte_next = text_byte;
                    if (first_byte)
                    begin
                        win.clear   = 1'b1;
                        wh_next     = '0;
                        bs_next     = '0;
                        pos_next    = '0;
                        spur_next   = '0;
                        pat_sr_next = pat_flat;
                        state_next  = ST_PAT;
                    end
                    else
                    begin
                        state_next = ST_PREP;
                    end
                end
            end
            ST_PAT:
            begin
                red_a.step  = 1'b1;
                red_a.din   = pat_sr_reg[PAT_W-1];
                red_b.step  = 1'b1;
                red_b.din   = (cnt_reg == CNT_W'(BYTE_W - 1));
                pat_sr_next = {pat_sr_reg[PAT_W-2:0], 1'b0};
                cnt_next    = cnt_reg + CNT_W'(1);
                if (cnt_reg == pat_last)
                begin
                    state_next = ST_PSAVE;
                end
            end
            ST_PSAVE:
            begin
                ph_next    = acc_a;
                lw_next    = acc_b;
                state_next = ST_PREP;
            end
            ST_PREP:
            begin
                red_a.clear   = 1'b1;
                red_b.clear   = 1'b1;
                was_full_next = full_now;
                sa_next       = {{BYTE_W{1'b0}}, wh_reg, byte_reg};
                sb_next       = full_now ? {drop_prod, {BYTE_W{1'b0}}} : '0;
                cnt_next      = '0;
                state_next    = ST_HASH;
            end
            ST_HASH:
            begin
                red_a.step = 1'b1;
                red_a.din  = sa_reg[STREAM_W-1];
                red_b.step = 1'b1;
                red_b.din  = sb_reg[STREAM_W-1];
                sa_next    = {sa_reg[STREAM_W-2:0], 1'b0};
                sb_next    = {sb_reg[STREAM_W-2:0], 1'b0};
                cnt_next   = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(STREAM_W - 1))
                begin
                    state_next = ST_HDONE;
                end
            end
            ST_HDONE:
            begin
                wh_next       = wh_new;
                win.shift     = 1'b1;
                found_next    = 1'b0;
                spur_hit_next = 1'b0;
                cmp_next      = '0;
                idx_next      = '0;
                pat_sr_next   = pat_flat;
                if (was_full_reg)
                begin
                    if (pos_reg != '1)
                    begin
                        pos_next = pos_reg + POS_W'(1);
                    end
                end
                else
                begin
                    bs_next = bs_inc;
                end
                if (full_after && (wh_new == ph_reg))
                begin
                    state_next = ST_CHECK;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_CHECK:
            begin
                cmp_next = cmp_reg + LEN_W'(1);
                if (win_rd != pat_sr_reg[PAT_W-1 -: BYTE_W])
                begin
                    spur_hit_next = 1'b1;
                    if (spur_reg != '1)
                    begin
                        spur_next = spur_reg + TOTAL_W'(1);
                    end
                    state_next = ST_FIN;
                end
                else if ({1'b0, idx_reg} == m_eff - LEN_W'(1))
                begin
                    found_next = 1'b1;
                    state_next = ST_FIN;
                end
                else
                begin
                    idx_next    = idx_reg + IDX_W'(1);
                    pat_sr_next = {pat_sr_reg[PAT_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
                end
            end
            ST_FIN:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next      = 1'b1;
                    o_full_next  = full_now;
                    o_found_next = found_reg;
                    o_spur_next  = spur_hit_reg;
                    o_cmp_next   = cmp_reg;
                    o_start_next = full_now ? start_sat : '0;
                    o_total_next = spur_reg;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg    <= LEN_W'(1);
            pat_lo_reg <= '0;
            pat_hi_reg <= '0;
            mod_reg    <= MODULUS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_LENGTH:  len_reg    <= cfg_wdata[LEN_W-1:0];
                REG_PAT_LO:  pat_lo_reg <= cfg_wdata;
                REG_PAT_HI:  pat_hi_reg <= cfg_wdata;
                REG_MODULUS: mod_reg    <= cfg_wdata[HASH_W-1:0];
                default:     len_reg    <= len_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            idx_reg      <= '0;
            cmp_reg      <= '0;
            was_full_reg <= 1'b0;
            found_reg    <= 1'b0;
            spur_hit_reg <= 1'b0;
            wh_reg       <= '0;
            ph_reg       <= '0;
            lw_reg       <= HASH_W'(1);
            bs_reg       <= '0;
            pos_reg      <= '0;
            spur_reg     <= '0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            idx_reg      <= idx_next;
            cmp_reg      <= cmp_next;
            was_full_reg <= was_full_next;
            found_reg    <= found_next;
            spur_hit_reg <= spur_hit_next;
            wh_reg       <= wh_next;
            ph_reg       <= ph_next;
            lw_reg       <= lw_next;
            bs_reg       <= bs_next;
            pos_reg      <= pos_next;
            spur_reg     <= spur_next;
            ov_reg       <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg    <= byte_next;
        sa_reg      <= sa_next;
        sb_reg      <= sb_next;
        pat_sr_reg  <= pat_sr_next;
        o_full_reg  <= o_full_next;
        o_found_reg <= o_found_next;
        o_spur_reg  <= o_spur_next;
        o_cmp_reg   <= o_cmp_next;
        o_start_reg <= o_start_next;
        o_total_reg <= o_total_next;
    end

    assign in_stall       = (state_reg != ST_IDLE);
    assign out_valid      = ov_reg;
    assign window_full    = o_full_reg;
    assign match_found    = o_found_reg;
    assign spurious_hit   = o_spur_reg;
    assign compare_count  = o_cmp_reg;
    assign match_start    = o_start_reg;
    assign spurious_total = o_total_reg;

`ifndef NO_ASSERTIONS
    // A window that is not yet full cannot have been checked.
    a_empty_no_check: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !window_full) |-> (!match_found && !spurious_hit &&
                                         (compare_count == '0)))
        else $error("result for a partial window reports a check");

    // A checked window is either a match or a spurious hit, never both.
    a_check_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(match_found && spurious_hit) &&
                      ((match_found || spurious_hit) == (compare_count != '0)))
        else $error("inconsistent outcome of the byte check");

    // A spurious hit is always counted in the running total.
    a_spur_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && spurious_hit) |-> (spurious_total != '0))
        else $error("spurious hit missing from the total");

    // The serial residues stay below the modulus while they are folding.
    a_residue_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_HASH) || (state_reg == ST_PAT)) |->
            ((acc_a < q_eff) && (acc_b < q_eff)))
        else $error("modular residue out of range");
`endif

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// Rolling hash substring search: block-level regression
// Streams texts with planted pattern copies, near misses and random bytes
// through the search block under several register settings and checks every
// result against a rolling-hash predictor held in the bench.
// ----------------------------------------------------------------------------
module tb
    import rhss_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT   = 5000;
    localparam int LONG_HOLD     = 400;
    localparam int SETTLE_CYCLES = 40;
    localparam int END_SETTLE    = 200;

    typedef struct packed {
        logic               full;
        logic               found;
        logic               spur;
        logic [LEN_W-1:0]   cmp;
        logic [START_W-1:0] start;
        logic [TOTAL_W-1:0] total;
    } window_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_addr;
    logic [CFG_W-1:0]     cfg_wdata;
    logic                 in_valid;
    logic                 in_stall;
    logic [BYTE_W-1:0]    text_byte;
    logic                 first_byte;
    logic                 out_valid;
    logic                 out_stall;
    logic                 window_full;
    logic                 match_found;
    logic                 spurious_hit;
    logic [LEN_W-1:0]     compare_count;
    logic [START_W-1:0]   match_start;
    logic [TOTAL_W-1:0]   spurious_total;

    // Register copies and search state of the predictor.
    logic [LEN_W-1:0]   cfg_len     = 5'd1;
    logic [CFG_W-1:0]   cfg_pat_lo  = '0;
    logic [CFG_W-1:0]   cfg_pat_hi  = '0;
    logic [HASH_W-1:0]  cfg_mod     = MODULUS_RESET;
    logic [BYTE_W-1:0]  win_bytes [MAX_PAT];
    logic [HASH_W-1:0]  win_hash    = '0;
    logic [HASH_W-1:0]  pat_hash    = '0;
    logic [HASH_W-1:0]  lead_weight = 16'd1;
    logic [LEN_W-1:0]   seen_count  = '0;
    logic [POS_W-1:0]   position    = '0;
    logic [TOTAL_W-1:0] spur_count  = '0;

    window_result_t pending_windows [$];

    int          error_count   = 0;
    int          items_sent    = 0;
    int          idle_cycles   = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_left     = 0;
    bit          hold_go       = 1'b0;
    bit          narrow_bytes  = 1'b0;
    logic [63:0] plan_len;
    logic [63:0] plan_lo;
    logic [63:0] plan_hi;
    logic [63:0] plan_mod;

    rolling_hash_substring_search dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .text_byte      (text_byte),
        .first_byte     (first_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .window_full    (window_full),
        .match_found    (match_found),
        .spurious_hit   (spurious_hit),
        .compare_count  (compare_count),
        .match_start    (match_start),
        .spurious_total (spurious_total)
    );

    always #6 clk = ~clk;

    initial
    begin
        foreach (win_bytes[i])
        begin
            win_bytes[i] = '0;
        end
    end

    function automatic int pattern_span();
        if (cfg_len == 0)
        begin
            return 1;
        end
        return (cfg_len > MAX_PAT) ? MAX_PAT : int'(cfg_len);
    endfunction

    function automatic logic [BYTE_W-1:0] pattern_byte(input int j);
        return (j < HALF_BYTES) ? cfg_pat_lo[BYTE_W*j +: BYTE_W]
                                : cfg_pat_hi[BYTE_W*(j-HALF_BYTES) +: BYTE_W];
    endfunction

    function automatic window_result_t predict_window(input logic [BYTE_W-1:0] b,
                                                      input logic first);
        window_result_t r;
        int unsigned    m;
        int unsigned    q;
        int unsigned    h;
        int unsigned    w;
        int unsigned    drop;
        bit             same;
        r = '0;
        m = pattern_span();
        q = (cfg_mod < MODULUS_MIN) ? 2 : 32'(cfg_mod);
        if (first)
        begin
            foreach (win_bytes[i])
            begin
                win_bytes[i] = '0;
            end
            win_hash   = '0;
            seen_count = '0;
            position   = '0;
            spur_count = '0;
            h = 0;
            w = 1;
            for (int i = 0; i < m; i++)
            begin
                h = (h * 256 + 32'(pattern_byte(i))) % q;
            end
            for (int i = 1; i < m; i++)
            begin
                w = (w * 256) % q;
            end
            pat_hash    = h[HASH_W-1:0];
            lead_weight = w[HASH_W-1:0];
        end
        if (seen_count >= m)
        begin
            drop = (32'(win_bytes[m-1]) * 32'(lead_weight)) % q;
            h = ((32'(win_hash) % q) + q - drop) % q;
            h = (h * 256 + 32'(b)) % q;
            win_hash = h[HASH_W-1:0];
            if (position != '1)
            begin
                position++;
            end
        end
        else
        begin
            h = ((32'(win_hash) % q) * 256 + 32'(b)) % q;
            win_hash = h[HASH_W-1:0];
            seen_count++;
        end
        for (int i = MAX_PAT - 1; i > 0; i--)
        begin
            win_bytes[i] = win_bytes[i-1];
        end
        win_bytes[0] = b;
        if (seen_count >= m)
        begin
            r.full  = 1'b1;
            r.start = START_W'(position);
            if (win_hash == pat_hash)
            begin
                same = 1'b1;
                for (int i = 0; i < m; i++)
                begin
                    r.cmp++;
                    if (win_bytes[m-1-i] != pattern_byte(i))
                    begin
                        same = 1'b0;
                        break;
                    end
                end
                if (same)
                begin
                    r.found = 1'b1;
                end
                else
                begin
                    r.spur = 1'b1;
                    if (spur_count != '1)
                    begin
                        spur_count++;
                    end
                end
            end
        end
        r.total = spur_count;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        error_count++;
        $display("%0t ns: mismatch on %s: got %0h, expected %0h", $realtime, what,
                 got, want);
    endtask

    // Register writes, input transfers and output transfers are all observed here,
    // so the predictor sees them in a fixed order.
    always @(posedge clk)
    begin
        window_result_t want;
        if (rst_n)
        begin
            idle_cycles++;
            if (cfg_we)
            begin
                idle_cycles = 0;
                case (cfg_addr)
                    REG_LENGTH:  cfg_len    = cfg_wdata[LEN_W-1:0];
                    REG_PAT_LO:  cfg_pat_lo = cfg_wdata;
                    REG_PAT_HI:  cfg_pat_hi = cfg_wdata;
                    REG_MODULUS: cfg_mod    = cfg_wdata[HASH_W-1:0];
                    default:     ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                idle_cycles = 0;
                pending_windows = {pending_windows, predict_window(text_byte, first_byte)};
            end
            if (out_valid && !out_stall)
            begin
                idle_cycles = 0;
                if (pending_windows.size() == 0)
                begin
                    report_mismatch("result with nothing pending", 64'(match_start), 64'd0);
                end
                else
                begin
                    want = pending_windows.pop_front();
                    if (window_full !== want.full)
                        report_mismatch("window_full", 64'(window_full), 64'(want.full));
                    if (match_found !== want.found)
                        report_mismatch("match_found", 64'(match_found), 64'(want.found));
                    if (spurious_hit !== want.spur)
                        report_mismatch("spurious_hit", 64'(spurious_hit), 64'(want.spur));
                    if (compare_count !== want.cmp)
                        report_mismatch("compare_count", 64'(compare_count), 64'(want.cmp));
                    if (match_start !== want.start)
                        report_mismatch("match_start", 64'(match_start), 64'(want.start));
                    if (spurious_total !== want.total)
                        report_mismatch("spurious_total", 64'(spurious_total),
                                        64'(want.total));
                end
            end
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t ns: no transfer for %0d cycles", $realtime, STALL_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Receiver: random stalls, or a long hold-off once one is requested.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_go)
            begin
                hold_go   = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    task automatic send_text_byte(input logic [BYTE_W-1:0] b, input logic first);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        text_byte  <= b;
        first_byte <= first;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        items_sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_windows.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [63:0] len, input logic [63:0] lo,
                              input logic [63:0] hi, input logic [63:0] q);
        write_reg(REG_LENGTH, len);
        write_reg(REG_PAT_LO, lo);
        write_reg(REG_PAT_HI, hi);
        write_reg(REG_MODULUS, q);
    endtask

    function automatic logic [BYTE_W-1:0] any_byte();
        return narrow_bytes ? BYTE_W'($urandom_range(3)) : BYTE_W'($urandom_range(255));
    endfunction

    task automatic choose_config();
        narrow_bytes = ($urandom_range(1) != 0);
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: plan_len = 64'($urandom_range(1, 4));
            6, 7:             plan_len = 64'($urandom_range(5, 16));
            8:                plan_len = 64'd16;
            default:          plan_len = ($urandom_range(1) != 0) ? 64'd0
                                                                  : 64'($urandom_range(17, 31));
        endcase
        plan_lo = {$urandom, $urandom};
        plan_hi = {$urandom, $urandom};
        if (narrow_bytes)
        begin
            plan_lo &= 64'h0303_0303_0303_0303;
            plan_hi &= 64'h0303_0303_0303_0303;
        end
        if ($urandom_range(7) == 0)
        begin
            plan_hi = '1;
        end
        case ($urandom_range(6))
            0:       plan_mod = 64'($urandom_range(2, 7));
            1:       plan_mod = 64'($urandom_range(1));
            2:       plan_mod = 64'd65535;
            3:       plan_mod = 64'd65521;
            4:       plan_mod = 64'd257;
            default: plan_mod = 64'($urandom_range(8, 65535));
        endcase
    endtask

    // One text: pattern copies, copies with one byte altered, random runs, and
    // now and then an unexpected restart.
    task automatic send_random_text(input int n, input bit restart);
        int                m;
        int                k;
        int                flip;
        int                run;
        logic [BYTE_W-1:0] b;
        m = pattern_span();
        k = 0;
        if (restart)
        begin
            send_text_byte(any_byte(), 1'b1);
        end
        while (k < n)
        begin
            case ($urandom_range(9))
                0, 1, 2, 3:
                begin
                    for (int j = 0; j < m; j++)
                    begin
                        send_text_byte(pattern_byte(j), 1'b0);
                    end
                    k += m;
                end
                4, 5:
                begin
                    flip = $urandom_range(m - 1);
                    for (int j = 0; j < m; j++)
                    begin
                        b = pattern_byte(j);
                        if (j == flip)
                        begin
                            b ^= BYTE_W'($urandom_range(1, narrow_bytes ? 3 : 255));
                        end
                        send_text_byte(b, 1'b0);
                    end
                    k += m;
                end
                6, 7, 8:
                begin
                    run = $urandom_range(1, 8);
                    repeat (run) send_text_byte(any_byte(), 1'b0);
                    k += run;
                end
                default:
                begin
                    send_text_byte(any_byte(), 1'b1);
                    k++;
                end
            endcase
        end
    endtask

    // Bytes before any text start use the reset pattern hash and weight.
    task automatic test_reset_state();
        send_text_byte(8'h00, 1'b0);
        send_text_byte(8'h0B, 1'b0);
        send_text_byte(8'h80, 1'b0);
        send_text_byte(8'hFF, 1'b0);
    endtask

    // An oversized length acts as the full sixteen bytes, with the widest modulus.
    task automatic test_full_length_match();
        drain_results();
        set_config(64'd31, '1, '0, 64'd65535);
        for (int j = 0; j < MAX_PAT; j++)
        begin
            send_text_byte(pattern_byte(j), j == 0);
        end
    endtask

    // Registers rewritten in the middle of a text, the modulus shrinking to its floor.
    task automatic test_mid_text_registers();
        drain_results();
        write_reg(REG_MODULUS, 64'd1);
        write_reg(REG_PAT_HI, '1);
        send_text_byte(8'hAA, 1'b0);
        send_text_byte(8'h55, 1'b0);
    endtask

    // A zero length acts as one byte and a zero modulus as two.
    task automatic test_short_pattern_clamps();
        drain_results();
        write_reg(REG_LENGTH, 64'd0);
        write_reg(REG_MODULUS, 64'd0);
        send_text_byte(8'hFF, 1'b1);
        send_text_byte(8'h01, 1'b0);
        send_text_byte(8'h00, 1'b0);
    endtask

    task automatic test_random_texts(input int send_pct, input int recv_pct, input int quota);
        int target;
        bit restart;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        target = items_sent + quota;
        while (items_sent < target)
        begin
            drain_results();
            choose_config();
            restart = 1'b1;
            case ($urandom_range(7))
                0:       write_reg(REG_LENGTH, plan_len);
                1:       write_reg(REG_MODULUS, plan_mod);
                2:       write_reg(REG_PAT_LO, plan_lo);
                3:       write_reg(REG_PAT_HI, plan_hi);
                default: set_config(plan_len, plan_lo, plan_hi, plan_mod);
            endcase
            if (items_sent > 0 && $urandom_range(3) == 0)
            begin
                restart = 1'b0;
            end
            send_random_text($urandom_range(20, 60), restart);
        end
    endtask

    // The receiver holds off while the sender keeps offering, so the block
    // fills and stalls its input; then the sender waits for every result.
    task automatic test_receiver_hold();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        drain_results();
        choose_config();
        set_config(plan_len, plan_lo, plan_hi, plan_mod);
        hold_go = 1'b1;
        send_random_text(40, 1'b1);
        drain_results();
    endtask

    initial
    begin
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_addr   = REG_LENGTH;
        cfg_wdata  = '0;
        in_valid   = 1'b0;
        text_byte  = '0;
        first_byte = 1'b0;
        send_idle_pct = 26;
        recv_idle_pct = 78;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_full_length_match();
        test_mid_text_registers();
        test_short_pattern_clamps();
        test_random_texts(26, 78, 180);
        test_random_texts(78, 26, 180);
        test_random_texts(0, 0, 140);
        test_receiver_hold();
        drain_results();
        repeat (END_SETTLE) @(posedge clk);
        if (pending_windows.size() != 0)
        begin
            report_mismatch("results never delivered", 64'(pending_windows.size()), 64'd0);
        end
        if (error_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/rhss_pkg.sv
hw/rtl/rhss_modred.sv
hw/rtl/rhss_window.sv
hw/rtl/rolling_hash_substring_search.sv
sim/tb.sv
